FILE: rtl/image_rotate_frame_buffer_macros.svh
// Assertion helpers shared by the rotator RTL.
`ifndef IMAGE_ROTATE_FRAME_BUFFER_MACROS_SVH
`define IMAGE_ROTATE_FRAME_BUFFER_MACROS_SVH

// prop must hold at every clock edge outside reset
`define IRFB_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cond must never be seen outside reset
`define IRFB_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/irfb_pkg.sv
`default_nettype none
package irfb_pkg;

   localparam int MAX_SIDE   = 128;
   localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
   localparam int IDX_W      = $clog2(MAX_SIDE);
   localparam int MEM_DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam int PROD_W     = IDX_W + SIDE_W + 1;
   localparam int CFG_W      = 8;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int COLOR_W    = 8;
   localparam int PIX_W      = 3 * COLOR_W;
   localparam int CMP_W      = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

   // response queue: covers every read in flight through the pipeline
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int OUT_CNT_W  = $clog2(2 * FIFO_DEPTH);

   localparam logic [MODE_W-1:0] ROT_CW90  = 2'd0;
   localparam logic [MODE_W-1:0] ROT_CCW90 = 2'd1;
   localparam logic [MODE_W-1:0] ROT_180   = 2'd2;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH   = 2'd0,
      REG_IMAGE_HEIGHT  = 2'd1,
      REG_ROTATION_MODE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               action;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] out_red;
      logic [COLOR_W-1:0] out_green;
      logic [COLOR_W-1:0] out_blue;
      logic               last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
      logic [MODE_W-1:0] mode;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic              is_read;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  pixel;
      logic              last;
   } mem_op_type;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
      logic [CMP_W-1:0] ve;
      ve = CMP_W'(v);
      if (ve == '0) begin
         return SIDE_W'(1);
      end else if (ve > CMP_W'(MAX_SIDE)) begin
         return SIDE_W'(MAX_SIDE);
      end
      return SIDE_W'(ve);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/irfb_ram.sv
`default_nettype none
module irfb_ram #(
   parameter  int WIDTH = 24,
   parameter  int DEPTH = 16384,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/irfb_addr_gen.sv
`default_nettype none
module irfb_addr_gen (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire irfb_pkg::cfg_type     cfg,
   input  wire logic                  clear,
   input  wire logic                  req_fire,
   input  wire irfb_pkg::req_type     req,
   output logic                       s1_read,
   output irfb_pkg::mem_op_type       mem_op
);
   import irfb_pkg::*;

   logic [IDX_W-1:0] load_row_ff, load_row_in;
   logic [IDX_W-1:0] load_col_ff, load_col_in;
   logic [IDX_W-1:0] read_row_ff, read_row_in;
   logic [IDX_W-1:0] read_col_ff, read_col_in;

   logic              s1_valid_ff;
   logic              s1_read_ff,  s1_read_in;
   logic [IDX_W-1:0]  s1_y_ff,     s1_y_in;
   logic [IDX_W-1:0]  s1_z_ff,     s1_z_in;
   logic [SIDE_W-1:0] s1_dw_ff,    s1_dw_in;
   logic [PIX_W-1:0]  s1_pixel_ff, s1_pixel_in;
   logic              s1_last_ff,  s1_last_in;

   logic              s2_valid_ff;
   logic              s2_read_ff;
   logic [ADDR_W-1:0] s2_addr_ff,  s2_addr_in;
   logic [PIX_W-1:0]  s2_pixel_ff;
   logic              s2_last_ff;

   logic              half_turn;
   logic [SIDE_W-1:0] dw, dh;
   logic [SIDE_W-1:0] load_col_nxt, load_row_nxt, read_col_nxt, read_row_nxt;
   logic [SIDE_W-1:0] h_m1_r, w_m1_c;
   logic [PROD_W-1:0] lin;

   assign half_turn = cfg.mode[1];
   assign dw = half_turn ? cfg.width  : cfg.height;
   assign dh = half_turn ? cfg.height : cfg.width;

   always_comb begin
      load_col_nxt = SIDE_W'(load_col_ff) + SIDE_W'(1);
      load_row_nxt = SIDE_W'(load_row_ff) + SIDE_W'(1);
      read_col_nxt = SIDE_W'(read_col_ff) + SIDE_W'(1);
      read_row_nxt = SIDE_W'(read_row_ff) + SIDE_W'(1);
      h_m1_r = cfg.height - SIDE_W'(1) - SIDE_W'(load_row_ff);
      w_m1_c = cfg.width  - SIDE_W'(1) - SIDE_W'(load_col_ff);

      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      read_row_in = read_row_ff;
      read_col_in = read_col_ff;

      s1_read_in  = req.action;
      s1_dw_in    = dw;
      s1_pixel_in = {req.red, req.green, req.blue};
      s1_last_in  = (SIDE_W'(read_row_ff) == dh - SIDE_W'(1)) &&
                    (SIDE_W'(read_col_ff) == dw - SIDE_W'(1));

      if (req.action == ACT_READ) begin
         s1_y_in = read_row_ff;
         s1_z_in = read_col_ff;
      end else if (half_turn) begin
         s1_y_in = IDX_W'(h_m1_r);
         s1_z_in = IDX_W'(w_m1_c);
      end else if (cfg.mode == ROT_CW90) begin
         s1_y_in = load_col_ff;
         s1_z_in = IDX_W'(h_m1_r);
      end else begin
         s1_y_in = IDX_W'(w_m1_c);
         s1_z_in = load_row_ff;
      end

      priority if (clear) begin
         load_row_in = '0;
         load_col_in = '0;
         read_row_in = '0;
         read_col_in = '0;
      end else if (req_fire && req.action == ACT_WRITE) begin
         if (load_col_nxt >= cfg.width) begin
            load_col_in = '0;
            load_row_in = (load_row_nxt >= cfg.height) ? '0 : IDX_W'(load_row_nxt);
         end else begin
            load_col_in = IDX_W'(load_col_nxt);
         end
      end else if (req_fire) begin
         if (read_col_nxt >= dw) begin
            read_col_in = '0;
            read_row_in = (read_row_nxt >= dh) ? '0 : IDX_W'(read_row_nxt);
         end else begin
            read_col_in = IDX_W'(read_col_nxt);
         end
      end else begin
      end
   end

   assign lin = PROD_W'(s1_y_ff) * PROD_W'(s1_dw_ff) + PROD_W'(s1_z_ff);
   assign s2_addr_in = ADDR_W'(lin);

   always_ff @(posedge clock) begin
      if (reset) begin
         load_row_ff <= '0;
         load_col_ff <= '0;
         read_row_ff <= '0;
         read_col_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         load_row_ff <= load_row_in;
         load_col_ff <= load_col_in;
         read_row_ff <= read_row_in;
         read_col_ff <= read_col_in;
         s1_valid_ff <= req_fire;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff  <= s1_read_in;
      s1_y_ff     <= s1_y_in;
      s1_z_ff     <= s1_z_in;
      s1_dw_ff    <= s1_dw_in;
      s1_pixel_ff <= s1_pixel_in;
      s1_last_ff  <= s1_last_in;
      s2_read_ff  <= s1_read_ff;
      s2_addr_ff  <= s2_addr_in;
      s2_pixel_ff <= s1_pixel_ff;
      s2_last_ff  <= s1_last_ff;
   end

   assign s1_read        = s1_valid_ff && s1_read_ff;
   assign mem_op.valid   = s2_valid_ff;
   assign mem_op.is_read = s2_read_ff;
   assign mem_op.addr    = s2_addr_ff;
   assign mem_op.pixel   = s2_pixel_ff;
   assign mem_op.last    = s2_last_ff;

endmodule
`default_nettype wire

FILE: rtl/irfb_rsp_fifo.sv
`default_nettype none
module irfb_rsp_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire irfb_pkg::rsp_type             push_data,
   input  wire logic                          pop,
   output logic                               out_valid,
   output irfb_pkg::rsp_type                  out_data,
   output logic [irfb_pkg::FIFO_CNT_W-1:0]    count
);
   import irfb_pkg::*;

   rsp_type               entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff,  count_in;
   logic                  do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule
`default_nettype wire

FILE: rtl/image_rotate_frame_buffer.sv
// Frame-buffer rotator: write requests load source pixels in raster order, read requests
// return the frame turned clockwise 90, counterclockwise 90 or 180 degrees, one pixel per
// read, with last_of_frame on the final one. Every request makes exactly one access to the
// single-port-per-direction frame RAM, so one request is taken per cycle while req_ready is
// high; a read passes two address stages, the RAM read, then the response queue. The request
// side holds off only while four reads are in flight or queued and no response is being taken.
// The frame RAM is not cleared at reset. A width, height or mode register write restarts the load
// and read positions at the first pixel; issue reads only after a full frame is loaded.
`default_nettype none
`include "image_rotate_frame_buffer_macros.svh"
module image_rotate_frame_buffer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire irfb_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output irfb_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [irfb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [irfb_pkg::CFG_W-1:0]   csr_data
);
   import irfb_pkg::*;

   logic [SIDE_W-1:0] width_ff,  width_in;
   logic [SIDE_W-1:0] height_ff, height_in;
   logic [MODE_W-1:0] mode_ff,   mode_in;
   logic              clear;
   logic              csr_fire;
   logic              req_fire;
   logic              s1_read;
   logic              s3_valid_ff;
   logic              s3_last_ff;
   logic              rd_en;
   logic              wr_en;
   logic [PIX_W-1:0]  rd_data;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [OUT_CNT_W-1:0]  inflight;
   cfg_type           cfg;
   mem_op_type        mem_op;
   rsp_type           push_data;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      clear     = 1'b0;
      if (csr_fire) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               width_in = clamp_side(csr_data);
               clear    = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = clamp_side(csr_data);
               clear     = 1'b1;
            end
            REG_ROTATION_MODE: begin
               mode_in = csr_data[MODE_W-1:0];
               clear   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_side(CFG_W'(128));
         height_ff <= clamp_side(CFG_W'(128));
         mode_ff   <= ROT_CW90;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
      end
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;
   assign cfg.mode   = mode_ff;

   // reads still owed a queue slot
   assign inflight = OUT_CNT_W'(s1_read) + OUT_CNT_W'(mem_op.valid && mem_op.is_read) +
                     OUT_CNT_W'(s3_valid_ff) + OUT_CNT_W'(fifo_count);
   assign req_ready = (inflight < OUT_CNT_W'(FIFO_DEPTH)) || (rsp_valid && rsp_ready);
   assign req_fire  = req_valid && req_ready;

   irfb_addr_gen u_addr_gen (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .clear    (clear),
      .req_fire (req_fire),
      .req      (req_data),
      .s1_read  (s1_read),
      .mem_op   (mem_op)
   );

   assign wr_en = mem_op.valid && !mem_op.is_read;
   assign rd_en = mem_op.valid &&  mem_op.is_read;

   irfb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MEM_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (mem_op.addr),
      .wr_data (mem_op.pixel),
      .rd_en   (rd_en),
      .rd_addr (mem_op.addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      s3_last_ff <= mem_op.last;
   end

   assign push_data.out_red       = rd_data[PIX_W-1 -: COLOR_W];
   assign push_data.out_green     = rd_data[COLOR_W +: COLOR_W];
   assign push_data.out_blue      = rd_data[COLOR_W-1:0];
   assign push_data.last_of_frame = s3_last_ff;

   irfb_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data (push_data),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .count     (fifo_count)
   );

   `IRFB_ASSERT_NEVER(a_credit_bound, clock, reset, inflight > OUT_CNT_W'(FIFO_DEPTH), "reads in flight exceed response queue")
   `IRFB_ASSERT_NEVER(a_no_overflow, clock, reset, s3_valid_ff && fifo_count == FIFO_CNT_W'(FIFO_DEPTH) && !rsp_ready, "response queue overflow")
   `IRFB_ASSERT_HOLDS(a_read_reaches_ram, clock, reset, (req_fire && req_data.action == ACT_READ) |-> ##3 s3_valid_ff, "read request lost in pipeline")

endmodule
`default_nettype wire

FILE: tb/image_rotate_frame_buffer_tb.sv
`timescale 1ns / 100ps
module image_rotate_frame_buffer_tb;
   import irfb_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int ITEM_GOAL     = 600;
   localparam int CALM_AFTER    = 480;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam logic [MODE_W-1:0]    ROT_SPARE       = 2'd3;

   typedef enum logic [1:0] {STEP_CSR, STEP_LOAD, STEP_FETCH} step_kind_type;

   typedef struct packed {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     value;
      logic [PIX_W-1:0]     rgb;
      logic                 typed;
      rsp_type              want;
   } script_step_type;

   // 1-wide, 2-high frames through every mode; pixel values chosen so each read is obvious
   localparam int SCRIPT_LEN = 23;
   localparam script_step_type SCRIPT [SCRIPT_LEN] = '{
      '{STEP_CSR,   REG_IMAGE_HEIGHT,  8'd2,               24'h0,     1'b0, '0},
      '{STEP_CSR,   REG_IMAGE_WIDTH,   8'd0,               24'h0,     1'b0, '0},
      '{STEP_LOAD,  '0,                '0,                 24'hFFFFFF, 1'b0, '0},
      '{STEP_LOAD,  '0,                '0,                 24'h000000, 1'b0, '0},
      '{STEP_FETCH, '0,                '0,                 24'h0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
      '{STEP_FETCH, '0,                '0,                 24'h0, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
      '{STEP_CSR,   REG_ROTATION_MODE, CFG_W'(ROT_CCW90),  24'h0,     1'b0, '0},
      '{STEP_LOAD,  '0,                '0,                 24'h123456, 1'b0, '0},
      '{STEP_LOAD,  '0,                '0,                 24'hABCDEF, 1'b0, '0},
      '{STEP_FETCH, '0,                '0,                 24'h0, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0}},
      '{STEP_FETCH, '0,                '0,                 24'h0, 1'b1, '{8'hAB, 8'hCD, 8'hEF, 1'b1}},
      // spare mode decodes as a half turn
      '{STEP_CSR,   REG_ROTATION_MODE, CFG_W'(ROT_SPARE),  24'h0,     1'b0, '0},
      '{STEP_LOAD,  '0,                '0,                 24'h010203, 1'b0, '0},
      '{STEP_LOAD,  '0,                '0,                 24'h804020, 1'b0, '0},
      '{STEP_FETCH, '0,                '0,                 24'h0, 1'b1, '{8'h80, 8'h40, 8'h20, 1'b0}},
      '{STEP_FETCH, '0,                '0,                 24'h0, 1'b1, '{8'h01, 8'h02, 8'h03, 1'b1}},
      // unmapped index must leave the counters alone; both have wrapped to the frame start
      '{STEP_CSR,   CSR_SPARE_INDEX,   8'hFF,              24'h0,     1'b0, '0},
      '{STEP_FETCH, '0,                '0,                 24'h0, 1'b1, '{8'h80, 8'h40, 8'h20, 1'b0}},
      '{STEP_LOAD,  '0,                '0,                 24'h7FFE01, 1'b0, '0},
      '{STEP_FETCH, '0,                '0,                 24'h0, 1'b1, '{8'h7F, 8'hFE, 8'h01, 1'b1}},
      // read ahead of the load returns the pixel left by the earlier frame
      '{STEP_CSR,   REG_ROTATION_MODE, CFG_W'(ROT_180),    24'h0,     1'b0, '0},
      '{STEP_LOAD,  '0,                '0,                 24'h5AA5C3, 1'b0, '0},
      '{STEP_FETCH, '0,                '0,                 24'h0,     1'b0, '0}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   // shadow of the block
   logic [PIX_W-1:0] frame_image [MEM_DEPTH];
   bit               pixel_loaded [MEM_DEPTH];
   int unsigned      side_w = MAX_SIDE;
   int unsigned      side_h = MAX_SIDE;
   logic [MODE_W-1:0] turn_mode = ROT_CW90;
   int unsigned      load_r = 0;
   int unsigned      load_c = 0;
   int unsigned      fetch_r = 0;
   int unsigned      fetch_c = 0;

   rsp_type pixels_due [$];
   rsp_type due_pixel;
   int      mismatches = 0;
   int      issued = 0;
   bit      calm = 1'b0;

   image_rotate_frame_buffer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int unsigned fit_side(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return 1;
      end else if (v > MAX_SIDE) begin
         return MAX_SIDE;
      end
      return v;
   endfunction

   function automatic bit half_turn();
      return (turn_mode & ROT_180) != '0;
   endfunction

   function automatic int unsigned out_width();
      return half_turn() ? side_w : side_h;
   endfunction

   function automatic bit fetch_is_loaded();
      return pixel_loaded[fetch_r * out_width() + fetch_c];
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] value);
      case (idx)
         REG_IMAGE_WIDTH:   side_w = fit_side(value);
         REG_IMAGE_HEIGHT:  side_h = fit_side(value);
         REG_ROTATION_MODE: turn_mode = value[MODE_W-1:0];
         default:           return;
      endcase
      load_r = 0;
      load_c = 0;
      fetch_r = 0;
      fetch_c = 0;
   endfunction

   // advances the shadow by one request; returns 1 with the rotated pixel on a read
   function automatic bit rotate_step(input req_type item, output rsp_type pixel);
      int unsigned dw, dh, row_d, col_d, addr;
      dw = out_width();
      dh = half_turn() ? side_h : side_w;
      pixel = '0;
      if (item.action == ACT_WRITE) begin
         if (half_turn()) begin
            row_d = side_h - 1 - load_r;
            col_d = side_w - 1 - load_c;
         end else if (turn_mode == ROT_CW90) begin
            row_d = load_c;
            col_d = side_h - 1 - load_r;
         end else begin
            row_d = side_w - 1 - load_c;
            col_d = load_r;
         end
         addr = row_d * dw + col_d;
         frame_image[addr] = {item.red, item.green, item.blue};
         pixel_loaded[addr] = 1'b1;
         load_c++;
         if (load_c >= side_w) begin
            load_c = 0;
            load_r = (load_r + 1 >= side_h) ? 0 : load_r + 1;
         end
         return 1'b0;
      end
      addr = fetch_r * dw + fetch_c;
      {pixel.out_red, pixel.out_green, pixel.out_blue} = frame_image[addr];
      pixel.last_of_frame = (fetch_r == dh - 1) && (fetch_c == dw - 1);
      fetch_c++;
      if (fetch_c >= dw) begin
         fetch_c = 0;
         fetch_r = (fetch_r + 1 >= dh) ? 0 : fetch_r + 1;
      end
      return 1'b1;
   endfunction

   task automatic wait_drained();
      while (pixels_due.size() != 0) @(posedge clock);
   endtask

   task automatic program_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] value);
      wait_drained();
      // loads still in the pipeline must land before the counters reset
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic push_request(input req_type item, input logic typed, input rsp_type want);
      rsp_type pixel;
      if (issued >= CALM_AFTER) calm = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (rotate_step(item, pixel)) begin
         pixels_due.push_back(typed ? want : pixel);
      end
      issued++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic run_frame_phase(input logic [CFG_W-1:0] raw_w, input logic [CFG_W-1:0] raw_h,
                                  input bit set_mode, input logic [MODE_W-1:0] mode,
                                  input bit poke_spare);
      int unsigned area, count;
      req_type     item;
      if (set_mode) begin
         program_register(REG_ROTATION_MODE, CFG_W'(mode));
      end
      program_register(REG_IMAGE_WIDTH, raw_w);
      program_register(REG_IMAGE_HEIGHT, raw_h);
      if (poke_spare) begin
         program_register(CSR_SPARE_INDEX, CFG_W'($urandom_range(0, 255)));
      end
      area  = side_w * side_h;
      count = area + $urandom_range(1, area) + 2;
      while (count != 0 && issued < ITEM_GOAL) begin
         item.red   = 8'($urandom_range(0, 255));
         item.green = 8'($urandom_range(0, 255));
         item.blue  = 8'($urandom_range(0, 255));
         // never read a store entry that nothing has written
         item.action = (fetch_is_loaded() && $urandom_range(0, 9) < 4) ? ACT_READ : ACT_WRITE;
         push_request(item, 1'b0, '0);
         count--;
      end
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         rsp_ready = calm || ($urandom_range(0, 2) != 0);
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pixels_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected pixel %02h %02h %02h last %0b", rsp_data.out_red,
                        rsp_data.out_green, rsp_data.out_blue, rsp_data.last_of_frame);
            end
         end else begin
            due_pixel = pixels_due.pop_front();
            if (rsp_data.out_red !== due_pixel.out_red ||
                rsp_data.out_green !== due_pixel.out_green ||
                rsp_data.out_blue !== due_pixel.out_blue ||
                rsp_data.last_of_frame !== due_pixel.last_of_frame) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display({"pixel mismatch: expected %02h %02h %02h last %0b, ",
                            "got %02h %02h %02h last %0b"},
                           due_pixel.out_red, due_pixel.out_green, due_pixel.out_blue,
                           due_pixel.last_of_frame, rsp_data.out_red, rsp_data.out_green,
                           rsp_data.out_blue, rsp_data.last_of_frame);
               end
            end
         end
      end
   end

   initial begin
      logic [CFG_W-1:0] raw_w, raw_h;
      int               failures;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (SCRIPT[i]) begin
         case (SCRIPT[i].kind)
            STEP_CSR:   program_register(SCRIPT[i].index, SCRIPT[i].value);
            STEP_LOAD:  push_request(req_type'({ACT_WRITE, SCRIPT[i].rgb}), 1'b0, '0);
            STEP_FETCH: push_request(req_type'({ACT_READ, SCRIPT[i].rgb}), SCRIPT[i].typed,
                                     SCRIPT[i].want);
            default:    ;
         endcase
      end

      // long thin frames at the size limits, then mostly small random frames
      run_frame_phase(8'd255, 8'd0, 1'b1, ROT_CW90, 1'b0);
      run_frame_phase(8'd1, 8'd128, 1'b1, ROT_CCW90, 1'b1);
      run_frame_phase(8'd128, 8'd1, 1'b1, ROT_SPARE, 1'b0);
      while (issued < ITEM_GOAL) begin
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
               raw_w = 8'($urandom_range(128, 255));
               raw_h = 8'($urandom_range(0, 2));
            end else begin
               raw_w = 8'($urandom_range(0, 2));
               raw_h = 8'($urandom_range(128, 255));
            end
         end else begin
            raw_w = 8'($urandom_range(1, 8));
            raw_h = 8'($urandom_range(1, 8));
            if (raw_w == 8'd1 && $urandom_range(0, 1) == 0) raw_w = '0;
            if (raw_h == 8'd1 && $urandom_range(0, 1) == 0) raw_h = '0;
         end
         run_frame_phase(raw_w, raw_h, $urandom_range(0, 1) == 1,
                         MODE_W'($urandom_range(0, 3)), $urandom_range(0, 5) == 0);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      failures = mismatches + pixels_due.size();
      if (pixels_due.size() != 0) begin
         $display("%0d pixels never returned", pixels_due.size());
      end
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
